// ===== rtl/bba_pkg.sv =====
// Shared types and constants of the bitmap block allocator.
package bba_pkg;

	localparam int POS_W      = 11;
	localparam int CMD_W      = 2;
	localparam int STAT_W     = 3;
	localparam int COUNT_W    = 12;
	localparam int SIZE_W     = 9;
	localparam int SIZE_RESET = 256;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_SET   = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_RANGE     = 3'd1,
		STAT_WAS_SET   = 3'd2,
		STAT_WAS_CLEAR = 3'd3,
		STAT_FULL      = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_MOD,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [POS_W-1:0] position;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [POS_W-1:0]   granted_position;
		logic [COUNT_W-1:0] used_count;
	} rsp_t;

endpackage

// ===== rtl/bba_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module bba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/bitmap_block_allocator_core.sv =====
// Bitmap block allocator: allocation bitmap in RAM, used-bit count and lowest-free hint.
// A transaction is decoded (S_DIV); unless decode rejects it (out of range, full, unused
// command), its word is modified and written back (S_MOD), then the hint is rescanned
// when needed (S_SCAN, one word read per cycle), and S_DONE loads the output register.
// A new request is accepted only in S_IDLE, once the previous result has been loaded.
// Reset and every size write start a clearing pass over all STORE_WORDS words (32 at defaults)
// that zeroes the bitmap; no input transaction is accepted until it has finished.
module bitmap_block_allocator_core
	import bba_pkg::*;
#(
	parameter int MAX_BYTES = 256,
	parameter int WORD_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  req_t              in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output rsp_t              out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] cfg_bytes_in_use
);

	// Geometry of the bitmap store, all derived from the two parameters.
	localparam int NMAX        = MAX_BYTES * 8;
	localparam int STORE_WORDS = (NMAX + WORD_BITS - 1) / WORD_BITS;
	localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int OW          = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int CNT_W       = $clog2(NMAX + 1);
	localparam int BASE_W      = $clog2(STORE_WORDS * WORD_BITS + 1);
	localparam int RESET_N     = ((SIZE_RESET > MAX_BYTES) ? MAX_BYTES : SIZE_RESET) * 8;

	// Division of a position by WORD_BITS is done with an exact reciprocal:
	// for any POS_W-bit x, (x * RECIP) >> SHIFT equals x / WORD_BITS.
	localparam int SHIFT = POS_W + OW;
	localparam int RW    = SHIFT + 1;
	localparam int RECIP = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;

	state_t state_q, state_d;

	logic                 accept;
	logic                 cfg_write;

	// Request and working registers.
	logic [CMD_W-1:0]     cmd_q;
	logic [POS_W-1:0]     pos_q;
	logic [POS_W-1:0]     quo_q;
	logic [AW-1:0]        addr_q;
	logic [OW-1:0]        off_q;
	logic [BASE_W-1:0]    base_q;
	logic [WORD_BITS-1:0] word_q;
	logic                 first_q;
	logic [AW-1:0]        clr_q;

	// Architectural state outside the RAM.
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     used_q;
	logic [CNT_W-1:0]     hint_pos_q;
	logic [AW-1:0]        hint_w_q;
	logic [OW-1:0]        hint_off_q;

	// Pending result and output register.
	status_t              stat_q;
	logic [CNT_W-1:0]     grant_q;
	logic                 out_valid_q;
	rsp_t                 out_data_q;

	// RAM port signals.
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	// Datapath decisions.
	logic [POS_W+RW-1:0]  quo_prod;
	logic [CNT_W-1:0]     cfg_n;
	logic                 div_err;
	status_t              div_stat;
	logic [AW-1:0]        div_addr;
	logic [OW-1:0]        div_off;
	logic [BASE_W-1:0]    div_base;
	logic [BASE_W-1:0]    quo_base;
	logic                 mod_bit;
	logic                 mod_err;
	status_t              mod_stat;
	logic                 mod_scan;
	logic [WORD_BITS-1:0] mod_word;
	logic [WORD_BITS-1:0] scan_data;
	logic [WORD_BITS-1:0] scan_free;
	logic                 scan_found;
	logic [OW-1:0]        scan_bit;
	logic [BASE_W-1:0]    scan_cand;
	logic [BASE_W-1:0]    scan_next_base;
	logic                 scan_last;
	logic                 scan_done;
	logic                 out_load;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The output register is refilled whenever it is empty or its transaction
	// completes in the same cycle, so a waiting result never blocks the next one
	// longer than necessary.
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// Managed bit count for a size write, saturated at the store size.
	always_comb begin
		if (32'(cfg_bytes_in_use) > MAX_BYTES) begin
			cfg_n = CNT_W'(NMAX);
		end else begin
			cfg_n = CNT_W'({cfg_bytes_in_use, 3'b000});
		end
	end

	assign quo_prod = (POS_W+RW)'(in_data.position) * (POS_W+RW)'(RECIP);

	// Decode stage: range and full checks, and the word address and bit offset
	// of the bit that the request touches. Allocation takes them from the hint.
	always_comb begin
		quo_base = BASE_W'(quo_q) * BASE_W'(WORD_BITS);
		div_err  = 1'b0;
		div_stat = STAT_OK;
		div_addr = AW'(quo_q);
		div_off  = OW'(BASE_W'(pos_q) - quo_base);
		div_base = quo_base;
		unique case (cmd_q)
			CMD_ALLOC: begin
				div_addr = hint_w_q;
				div_off  = hint_off_q;
				div_base = BASE_W'(hint_pos_q) - BASE_W'(hint_off_q);
				if (hint_pos_q >= n_q) begin
					div_err  = 1'b1;
					div_stat = STAT_FULL;
				end
			end
			CMD_SET, CMD_CLEAR: begin
				if (32'(pos_q) >= 32'(n_q)) begin
					div_err  = 1'b1;
					div_stat = STAT_RANGE;
				end
			end
			default: begin
				div_err  = 1'b1;
				div_stat = STAT_RANGE;
			end
		endcase
	end

	// Modify stage: the addressed word has arrived from the RAM.
	always_comb begin
		mod_bit  = ram_rdata[off_q];
		mod_word = ram_rdata;
		mod_err  = 1'b0;
		mod_stat = STAT_OK;
		mod_scan = 1'b0;
		unique case (cmd_q)
			CMD_ALLOC: begin
				mod_word[off_q] = 1'b1;
				mod_scan        = 1'b1;
			end
			CMD_SET: begin
				mod_word[off_q] = 1'b1;
				if (mod_bit) begin
					mod_err  = 1'b1;
					mod_stat = STAT_WAS_SET;
				end else begin
					mod_scan = (32'(pos_q) == 32'(hint_pos_q));
				end
			end
			CMD_CLEAR: begin
				mod_word[off_q] = 1'b0;
				if (!mod_bit) begin
					mod_err  = 1'b1;
					mod_stat = STAT_WAS_CLEAR;
				end
			end
			default: begin
				mod_err  = 1'b1;
				mod_stat = STAT_RANGE;
			end
		endcase
	end

	// Scan stage: one bitmap word per cycle. The first word is the one just
	// written, taken from word_q; bits below the starting offset are ignored.
	always_comb begin
		scan_data  = first_q ? word_q : ram_rdata;
		scan_found = 1'b0;
		scan_bit   = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			scan_free[i] = !scan_data[i] && (i >= 32'(off_q));
		end
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (scan_free[i]) begin
				scan_found = 1'b1;
				scan_bit   = OW'(i);
			end
		end
		scan_cand      = base_q + BASE_W'(scan_bit);
		scan_next_base = base_q + BASE_W'(WORD_BITS);
		scan_last      = (scan_next_base >= BASE_W'(n_q)) ||
		                 (addr_q == AW'(STORE_WORDS - 1));
		scan_done      = scan_found || scan_last;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == AW'(STORE_WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				state_d = div_err ? S_DONE : S_MOD;
			end
			S_MOD: begin
				state_d = (!mod_err && mod_scan) ? S_SCAN : S_DONE;
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
		if (cfg_write) begin
			state_d = S_CLEAR;
		end
	end

	// Handshake and RAM controls.
	always_comb begin
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = mod_word;
		ram_re    = 1'b0;
		ram_raddr = div_addr;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_IDLE: begin
				in_stall = 1'b0;
			end
			S_DIV: begin
				ram_re = !div_err;
			end
			S_MOD: begin
				ram_we = !mod_err;
			end
			S_SCAN: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(addr_q + 1'b1);
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			n_q         <= CNT_W'(RESET_N);
			used_q      <= '0;
			hint_pos_q  <= '0;
			hint_w_q    <= '0;
			hint_off_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			// A size write restarts the block with an empty bitmap.
			if (cfg_write) begin
				n_q        <= cfg_n;
				clr_q      <= '0;
				used_q     <= '0;
				hint_pos_q <= '0;
				hint_w_q   <= '0;
				hint_off_q <= '0;
			end else begin
				if (state_q == S_CLEAR) begin
					clr_q <= AW'(clr_q + 1'b1);
				end

				if (state_q == S_MOD && !mod_err) begin
					unique case (cmd_q)
						CMD_ALLOC, CMD_SET: begin
							used_q <= CNT_W'(used_q + 1'b1);
						end
						CMD_CLEAR: begin
							if (used_q != '0) begin
								used_q <= CNT_W'(used_q - 1'b1);
							end
							// A freed bit below the hint becomes the new lowest free bit.
							if (32'(pos_q) < 32'(hint_pos_q)) begin
								hint_pos_q <= CNT_W'(pos_q);
								hint_w_q   <= addr_q;
								hint_off_q <= off_q;
							end
						end
						default: begin
						end
					endcase
				end

				if (state_q == S_SCAN && scan_done) begin
					if (scan_found && (scan_cand < BASE_W'(n_q))) begin
						hint_pos_q <= CNT_W'(scan_cand);
						hint_w_q   <= addr_q;
						hint_off_q <= scan_bit;
					end else begin
						hint_pos_q <= n_q;
					end
				end
			end
		end
	end

	// Payload and working registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_data.command;
			pos_q <= in_data.position;
			quo_q <= POS_W'(quo_prod >> SHIFT);
		end

		if (state_q == S_DIV) begin
			addr_q  <= div_addr;
			off_q   <= div_off;
			base_q  <= div_base;
			stat_q  <= div_stat;
			grant_q <= '0;
		end

		if (state_q == S_MOD) begin
			word_q  <= mod_word;
			first_q <= 1'b1;
			stat_q  <= mod_stat;
			if (cmd_q == CMD_ALLOC) begin
				grant_q <= hint_pos_q;
			end
		end

		if (state_q == S_SCAN && !scan_done) begin
			addr_q  <= AW'(addr_q + 1'b1);
			base_q  <= scan_next_base;
			off_q   <= '0;
			first_q <= 1'b0;
		end

		if (out_load) begin
			out_data_q.status           <= stat_q;
			out_data_q.granted_position <= POS_W'(grant_q);
			out_data_q.used_count       <= COUNT_W'(used_q);
		end
	end

	bba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (STORE_WORDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

`ifndef NO_ASSERTIONS
	a_used_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= n_q)
		else $error("used-bit count exceeds the managed bit count");

	a_hint_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		hint_pos_q <= n_q)
		else $error("free hint lies beyond the managed bits");

	a_scan_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> base_q < BASE_W'(n_q))
		else $error("hint scan reads a word beyond the managed bits");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && !cfg_write |=> out_valid_q && state_q == S_IDLE)
		else $error("finished result did not reach the output register");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench of the bitmap block allocator core: random and directed requests.
module tb_top;
	import bba_pkg::*;

	// The block is built at its default size limits. The shadow map below covers
	// every bit that the largest size can manage.
	localparam int MAX_BYTES      = 256;
	localparam int WORD_BITS      = 64;
	localparam int MAP_BITS       = MAX_BYTES * 8;

	// The package leaves command code 3 unnamed. The block must answer it with an
	// out-of-range status, so the stimulus needs a name for it.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// The receiver's long hold-off. It is much longer than the block's own
	// buffering, so the sender backs up behind a stalled input.
	localparam int HOLD_CYCLES    = 300;

	// Cycles without any accepted transaction before the run is abandoned. The
	// slowest correct stretch is the long hold-off above plus a clearing pass, a
	// full rescan and two idle bursts, which is well under this.
	localparam int WATCHDOG_LIMIT = 4000;

	logic              clk;
	logic              arst_n           = 1'b0;
	logic              in_valid         = 1'b0;
	logic              in_stall;
	req_t              in_data          = '0;
	logic              out_valid;
	logic              out_stall        = 1'b0;
	rsp_t              out_data;
	logic              cfg_valid        = 1'b0;
	logic              cfg_ready;
	logic [SIZE_W-1:0] cfg_bytes_in_use = '0;

	// Requests that wait to be offered, and the results that accepted requests
	// are owed, oldest first.
	req_t pending_reqs[$];
	rsp_t expected_rsps[$];

	// Shadow copy of the allocator: the bitmap, the number of set bits, the
	// lowest free bit and the size register as last written.
	bit          alloc_map [MAP_BITS];
	int unsigned used_total   = 0;
	int unsigned free_hint    = 0;
	int unsigned size_bytes   = SIZE_RESET;

	int          error_count  = 0;
	int unsigned send_gap     = 0;
	int unsigned recv_gap     = 0;
	int unsigned hold_left    = 0;
	int unsigned holds_wanted = 0;
	int unsigned holds_served = 0;
	int unsigned quiet_cycles = 0;

	// Set for the last phase of the run. Neither side idles after that.
	bit          calm_tail    = 1'b0;

	bitmap_block_allocator_core #(
		.MAX_BYTES(MAX_BYTES),
		.WORD_BITS(WORD_BITS)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_bytes_in_use(cfg_bytes_in_use)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Shadow allocator
	// ------------------------------------------------------------------

	// Sizes above the block's limit saturate, and a size of zero manages no bits.
	function automatic int unsigned managed_count();
		return (size_bytes > MAX_BYTES ? MAX_BYTES : size_bytes) * 8;
	endfunction

	// Lowest free bit at or above the start. The count of managed bits stands
	// for "none left", which is also what a full map keeps in the hint.
	function automatic int unsigned next_free(int unsigned start, int unsigned n);
		for (int unsigned p = start; p < n; p++) begin
			if (!alloc_map[p])
				return p;
		end
		return n;
	endfunction

	// Applies one accepted request to the shadow state and returns the result
	// that the block owes for it. Failed requests change nothing, and the
	// granted position is zero everywhere except in a successful allocation.
	function automatic rsp_t allocator_result(req_t r);
		rsp_t        res;
		int unsigned n;
		int unsigned p;
		n          = managed_count();
		p          = r.position;
		res        = '0;
		res.status = STAT_OK;
		case (r.command)
		CMD_ALLOC: begin
			if (free_hint >= n) begin
				res.status = STAT_FULL;
			end else begin
				alloc_map[free_hint]   = 1'b1;
				used_total++;
				res.granted_position = POS_W'(free_hint);
				free_hint            = next_free(free_hint + 1, n);
			end
		end
		CMD_SET: begin
			if (p >= n) begin
				res.status = STAT_RANGE;
			end else if (alloc_map[p]) begin
				res.status = STAT_WAS_SET;
			end else begin
				alloc_map[p] = 1'b1;
				used_total++;
				// Taking the bit that the hint names pushes the hint upward.
				if (p == free_hint)
					free_hint = next_free(p + 1, n);
			end
		end
		CMD_CLEAR: begin
			if (p >= n) begin
				res.status = STAT_RANGE;
			end else if (!alloc_map[p]) begin
				res.status = STAT_WAS_CLEAR;
			end else begin
				alloc_map[p] = 1'b0;
				if (used_total > 0)
					used_total--;
				if (p < free_hint)
					free_hint = p;
			end
		end
		default: begin
			res.status = STAT_RANGE;
		end
		endcase
		res.used_count = COUNT_W'(used_total);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		error_count++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	task automatic check_result(input rsp_t got);
		rsp_t want;
		if (expected_rsps.size() == 0) begin
			report_mismatch($sformatf("result with nothing outstanding: status %0d pos %0d count %0d",
				got.status, got.granted_position, got.used_count));
		end else begin
			want = expected_rsps.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.granted_position !== want.granted_position)
				report_mismatch($sformatf("granted_position %0d, expected %0d",
					got.granted_position, want.granted_position));
			if (got.used_count !== want.used_count)
				report_mismatch($sformatf("used_count %0d, expected %0d",
					got.used_count, want.used_count));
		end
	endtask

	// ------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------

	// An offered request holds until it is accepted. Only then does the driver
	// either start an idle burst or offer the next pending request. Every
	// accepted transaction is predicted at once, so the results stay in order.
	always @(posedge clk) begin
		req_t next_req;
		logic next_valid;
		if (in_valid && !in_stall)
			expected_rsps.push_back(allocator_result(in_data));
		next_valid = in_valid;
		next_req   = in_data;
		if (arst_n && !(in_valid && in_stall)) begin
			next_valid = 1'b0;
			if (send_gap != 0) begin
				send_gap--;
			end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
				// This cycle is the first of an idle burst.
				send_gap = $urandom_range(0, 15);
			end else if (pending_reqs.size() != 0) begin
				next_req   = pending_reqs.pop_front();
				next_valid = 1'b1;
			end
		end
		in_valid <= next_valid;
		in_data  <= next_req;
	end

	// ------------------------------------------------------------------
	// Result monitor and receiver stalls
	// ------------------------------------------------------------------

	// The stall seen at this edge is the one driven at the last edge, so a
	// result counts as taken exactly when the block sees it taken. A long hold
	// asked for by the stimulus takes precedence over the short random bursts.
	always @(posedge clk) begin
		logic next_stall;
		if (out_valid && !out_stall)
			check_result(out_data);
		if (holds_served != holds_wanted) begin
			hold_left = HOLD_CYCLES;
			holds_served++;
		end
		next_stall = 1'b0;
		if (hold_left != 0) begin
			next_stall = 1'b1;
			hold_left--;
		end else if (recv_gap != 0) begin
			next_stall = 1'b1;
			recv_gap--;
		end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
			next_stall = 1'b1;
			recv_gap   = $urandom_range(0, 15);
		end
		out_stall <= next_stall;
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------

	// Any transaction on any channel counts as progress.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic queue_req(input logic [CMD_W-1:0] cmd, input int unsigned pos);
		pending_reqs.push_back('{command: cmd, position: POS_W'(pos)});
	endtask

	// Most positions fall inside the managed range, and most of those in the
	// lowest two words, so that sets and clears keep hitting bits that were
	// already touched. The rest spread over the whole field.
	function automatic int unsigned pick_position(int unsigned n);
		int unsigned q;
		q = $urandom_range(0, 9);
		if (n != 0 && q < 6)
			return $urandom_range(0, (n < 128 ? n : 128) - 1);
		if (n != 0 && q < 8)
			return $urandom_range(0, n - 1);
		return $urandom_range(0, MAP_BITS - 1);
	endfunction

	task automatic queue_random(input int count);
		int unsigned      r;
		logic [CMD_W-1:0] cmd;
		for (int i = 0; i < count; i++) begin
			r   = $urandom_range(0, 99);
			cmd = r < 40 ? CMD_ALLOC : r < 68 ? CMD_SET : r < 96 ? CMD_CLEAR : CMD_UNUSED;
			queue_req(cmd, pick_position(managed_count()));
		end
	endtask

	// Returns at a falling edge once every request has been accepted and every
	// result has come back.
	task automatic wait_until_drained();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0);
	endtask

	// A size write re-initializes the block: the bitmap, the count and the hint
	// all start over. The shadow state follows at the edge of the transaction.
	task automatic write_size(input logic [SIZE_W-1:0] bytes);
		// Every request yields a result, so the block is idle once the last one
		// is out. The extra margin before the write costs nothing.
		repeat (4) @(negedge clk);
		@(posedge clk);
		cfg_valid        <= 1'b1;
		cfg_bytes_in_use <= bytes;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid  <= 1'b0;
		size_bytes = bytes;
		used_total = 0;
		free_hint  = 0;
		for (int p = 0; p < MAP_BITS; p++)
			alloc_map[p] = 1'b0;
		@(negedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Full size after reset. The first allocations take the lowest bits, the
		// top bit of the map can be set and cleared, a failed set or clear leaves
		// the count alone, a set at the hint pushes it past an already taken bit,
		// and a clear below the hint pulls it back down.
		queue_req(CMD_ALLOC, 2047);
		queue_req(CMD_ALLOC, 0);
		queue_req(CMD_SET, 2047);
		queue_req(CMD_SET, 2047);
		queue_req(CMD_CLEAR, 2047);
		queue_req(CMD_CLEAR, 2047);
		queue_req(CMD_SET, 3);
		queue_req(CMD_SET, 2);
		queue_req(CMD_ALLOC, 1024);
		queue_req(CMD_SET, 1024);
		queue_req(CMD_CLEAR, 1024);
		queue_req(CMD_CLEAR, 1);
		queue_req(CMD_ALLOC, 0);
		queue_req(CMD_UNUSED, 0);
		queue_req(CMD_UNUSED, 2047);
		queue_random(250);
		// The receiver holds off while plenty of requests are still queued, so
		// the block fills up and stalls its input.
		holds_wanted++;
		wait_until_drained();

		// One byte: eight bits fill up quickly, allocation then reports full, and
		// everything from bit 8 upward is out of range.
		write_size(9'd1);
		repeat (9) queue_req(CMD_ALLOC, 0);
		queue_req(CMD_SET, 8);
		queue_req(CMD_CLEAR, 2047);
		queue_req(CMD_SET, 7);
		queue_req(CMD_CLEAR, 3);
		queue_req(CMD_ALLOC, 0);
		queue_req(CMD_CLEAR, 0);
		queue_req(CMD_CLEAR, 7);
		queue_req(CMD_SET, 0);
		queue_random(150);
		wait_until_drained();

		// Zero size manages no bits at all.
		write_size(9'd0);
		queue_req(CMD_ALLOC, 0);
		queue_req(CMD_SET, 0);
		queue_req(CMD_CLEAR, 0);
		queue_req(CMD_UNUSED, 5);
		queue_random(20);
		wait_until_drained();

		// All ones saturates at the largest map. Halfway through, the sender
		// waits for every outstanding result before it carries on.
		write_size(9'd511);
		queue_random(150);
		wait_until_drained();
		queue_random(150);
		wait_until_drained();

		// Small maps, where the map fills and empties many times, one size just
		// above the limit and the reset size written explicitly.
		write_size(9'd2);
		queue_random(80);
		wait_until_drained();
		write_size(9'd257);
		queue_random(80);
		wait_until_drained();
		write_size(SIZE_W'($urandom_range(3, 16)));
		queue_random(80);
		wait_until_drained();
		write_size(SIZE_W'(SIZE_RESET));
		queue_random(80);
		wait_until_drained();

		// Last phase runs at full rate on both sides.
		calm_tail = 1'b1;
		write_size(9'd3);
		queue_random(150);
		wait_until_drained();

		// A rescan reads one bitmap word per cycle; this final wait catches any stray
		// result that is still on its way.
		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
